FILE: src/bfpc_pkg.sv
// Shared constants, types and register codes of the bit fault persistence counter.
`default_nettype none

package bfpc_pkg;

	localparam int UNIT_COUNT_DEF      = 8;
	localparam int FAULT_THRESHOLD_DEF = 3;

	localparam int BANK_COUNT  = 9;
	localparam int CODE_NUM    = 8;
	localparam int KIND_W      = 8;
	localparam int UNIT_W      = 3;
	localparam int BANK_W      = 4;
	localparam int BYTE_W      = 8;
	localparam int BYTE_NUM    = 4;

	localparam int CNT_W       = 3;
	localparam int CNT_NUM     = 16;
	localparam int WORD_W      = CNT_NUM * CNT_W;

	localparam int WIDE_GROUPS = 3;
	localparam int WIDE_BITS   = 5;
	localparam int NARROW_BITS = 4;

	localparam int PADDR_W     = 4;
	localparam int PDATA_W     = 64;
	localparam int REG_SEL_BIT = 3;

	typedef logic [BANK_W-1:0] bank_t;

	// Merge and break banks use the wide counter layout.
	localparam bank_t BANK_BREAK = bank_t'(1);
	localparam bank_t BANK_LAST  = bank_t'(BANK_COUNT - 1);

	typedef enum logic {
		REG_CODES = 1'b0,
		REG_LAST  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic  matched;
		bank_t bank;
	} match_t;

endpackage

`default_nettype wire

FILE: src/bfpc_regs.sv
// Configuration register file with its APB-style access port.
`default_nettype none

module bfpc_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [bfpc_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [bfpc_pkg::PDATA_W-1:0]   pwdata,
	output logic      [bfpc_pkg::PDATA_W-1:0]   prdata,
	output logic                                pready,
	output logic      [bfpc_pkg::CODE_NUM*bfpc_pkg::KIND_W-1:0] codes,
	output logic      [bfpc_pkg::KIND_W-1:0]    code_last
);

	logic [bfpc_pkg::CODE_NUM*bfpc_pkg::KIND_W-1:0] codes_q;
	logic [bfpc_pkg::KIND_W-1:0]                    last_q;
	bfpc_pkg::reg_idx_t                             idx;

	assign idx = bfpc_pkg::reg_idx_t'(paddr[bfpc_pkg::REG_SEL_BIT]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q <= '0;
			last_q  <= '0;
		end else if (psel && penable && pwrite) begin
			case (idx)
				bfpc_pkg::REG_CODES: codes_q <= pwdata;
				bfpc_pkg::REG_LAST:  last_q  <= pwdata[bfpc_pkg::KIND_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			bfpc_pkg::REG_CODES: prdata = codes_q;
			bfpc_pkg::REG_LAST:  prdata = {{(bfpc_pkg::PDATA_W-bfpc_pkg::KIND_W){1'b0}}, last_q};
			default:             prdata = '0;
		endcase
	end

	assign pready    = 1'b1;
	assign codes     = codes_q;
	assign code_last = last_q;

endmodule

`default_nettype wire

FILE: src/bfpc_match.sv
// Kind code match: picks the first bank whose code equals the kind byte.
`default_nettype none

module bfpc_match #(
	parameter int UNIT_COUNT = bfpc_pkg::UNIT_COUNT_DEF
) (
	input  wire logic [bfpc_pkg::KIND_W-1:0]                    kind_byte,
	input  wire logic [bfpc_pkg::UNIT_W-1:0]                    unit,
	input  wire logic [bfpc_pkg::CODE_NUM*bfpc_pkg::KIND_W-1:0] codes,
	input  wire logic [bfpc_pkg::KIND_W-1:0]                    code_last,
	output bfpc_pkg::match_t                                    result
);

	logic           hit;
	logic           in_range;
	bfpc_pkg::bank_t sel;

	// Scan from the highest bank down so that the lowest matching bank wins.
	always_comb begin
		hit = 1'b0;
		sel = '0;
		if (code_last == kind_byte) begin
			hit = 1'b1;
			sel = bfpc_pkg::BANK_LAST;
		end
		for (int b = bfpc_pkg::CODE_NUM - 1; b >= 0; b--) begin
			if (codes[b*bfpc_pkg::KIND_W +: bfpc_pkg::KIND_W] == kind_byte) begin
				hit = 1'b1;
				sel = bfpc_pkg::bank_t'(b);
			end
		end
	end

	assign in_range       = 32'(unit) < UNIT_COUNT;
	assign result.matched = hit && in_range;
	assign result.bank    = (hit && in_range) ? sel : '0;

endmodule

`default_nettype wire

FILE: src/bfpc_cnt_mem.sv
// Counter word memory with one read and one write port and a clearing sweep after reset.
`default_nettype none

module bfpc_cnt_mem #(
	parameter int DEPTH = bfpc_pkg::UNIT_COUNT_DEF * bfpc_pkg::BANK_COUNT,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         rd_en,
	input  wire logic [AW-1:0]                rd_addr,
	output logic      [bfpc_pkg::WORD_W-1:0]  rd_data,
	input  wire logic                         wr_en,
	input  wire logic [AW-1:0]                wr_addr,
	input  wire logic [bfpc_pkg::WORD_W-1:0]  wr_data,
	output logic                              busy
);

	logic [bfpc_pkg::WORD_W-1:0] mem_q [DEPTH];
	logic [bfpc_pkg::WORD_W-1:0] rd_data_q;
	logic                        clr_busy_q;
	logic [AW-1:0]               clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	// A read at the address being written returns the old word.
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem_q[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = clr_busy_q;

endmodule

`default_nettype wire

FILE: src/bit_fault_persistence_counter.sv
// Top level of the bit fault persistence counter: pipeline, counter update and ports.
//
// Each message transfer selects a counter bank by its kind byte and updates that bank's
// 3-bit persistence counters, kept as one 48-bit word per unit and bank in a single-port-read,
// single-port-write memory. A message is read from memory at its transfer, updated in stage s1
// and written back when s1 advances, and its result is loaded into the output register at that
// same edge; a new message is taken every cycle while results are taken.
// A message that hits the word written back in the same cycle gets that word by forwarding.
// After reset the memory is cleared one word per cycle, during which msg_ready stays low;
// register writes are taken at all times.
`default_nettype none

module bit_fault_persistence_counter #(
	parameter int UNIT_COUNT      = bfpc_pkg::UNIT_COUNT_DEF,
	parameter int FAULT_THRESHOLD = bfpc_pkg::FAULT_THRESHOLD_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [bfpc_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [bfpc_pkg::PDATA_W-1:0]  pwdata,
	output logic      [bfpc_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready,
	input  wire logic                          msg_valid,
	output logic                               msg_ready,
	input  wire logic [bfpc_pkg::UNIT_W-1:0]   unit,
	input  wire logic [bfpc_pkg::KIND_W-1:0]   kind_byte,
	input  wire logic [bfpc_pkg::BYTE_W-1:0]   data_byte_1,
	input  wire logic [bfpc_pkg::BYTE_W-1:0]   data_byte_2,
	input  wire logic [bfpc_pkg::BYTE_W-1:0]   data_byte_3,
	input  wire logic [bfpc_pkg::BYTE_W-1:0]   data_byte_4,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output logic      [bfpc_pkg::UNIT_W-1:0]   unit_out,
	output logic                               matched,
	output logic      [bfpc_pkg::BANK_W-1:0]   bank,
	output logic                               fault
);

	localparam int DEPTH = UNIT_COUNT * bfpc_pkg::BANK_COUNT;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [bfpc_pkg::CNT_W:0] TH_V  = FAULT_THRESHOLD[bfpc_pkg::CNT_W:0];
	localparam logic [bfpc_pkg::CNT_W:0] SAT_V = TH_V + {{bfpc_pkg::CNT_W{1'b0}}, 1'b1};

	logic [bfpc_pkg::CODE_NUM*bfpc_pkg::KIND_W-1:0] codes;
	logic [bfpc_pkg::KIND_W-1:0]                    code_last;
	bfpc_pkg::match_t                               m_in;

	logic                         msg_acc;
	logic                         s1_adv;
	logic                         clr_busy;
	logic [AW-1:0]                addr_in;

	logic                         v_s1;
	logic [bfpc_pkg::UNIT_W-1:0]  unit_s1;
	bfpc_pkg::match_t             m_s1;
	logic [AW-1:0]                addr_s1;
	logic [bfpc_pkg::BYTE_W-1:0]  data_s1 [bfpc_pkg::BYTE_NUM];
	logic                         fwd_s1;
	logic [bfpc_pkg::WORD_W-1:0]  fwd_word_s1;

	logic [bfpc_pkg::WORD_W-1:0]  rd_data;
	logic [bfpc_pkg::WORD_W-1:0]  old_word;
	logic [bfpc_pkg::WORD_W-1:0]  new_word;
	logic [bfpc_pkg::CNT_NUM-1:0] hit_vec;
	logic                         wide_s1;
	logic                         wr_en;

	logic                         res_valid_q;
	logic [bfpc_pkg::UNIT_W-1:0]  unit_out_q;
	logic                         matched_q;
	bfpc_pkg::bank_t              bank_q;
	logic                         fault_q;

	bfpc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.codes     (codes),
		.code_last (code_last)
	);

	bfpc_match #(
		.UNIT_COUNT (UNIT_COUNT)
	) u_match (
		.kind_byte (kind_byte),
		.unit      (unit),
		.codes     (codes),
		.code_last (code_last),
		.result    (m_in)
	);

	assign s1_adv    = !res_valid_q || res_ready;
	assign msg_ready = !clr_busy && (!v_s1 || s1_adv);
	assign msg_acc   = msg_valid && msg_ready;
	assign addr_in   = AW'(unit) * AW'(bfpc_pkg::BANK_COUNT) + AW'(m_in.bank);
	assign wr_en     = v_s1 && s1_adv && m_s1.matched;

	bfpc_cnt_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (msg_acc && m_in.matched),
		.rd_addr (addr_in),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (new_word),
		.busy    (clr_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (msg_acc) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	// The memory returns the old word when the previous message writes the same entry
	// at this transfer, so the written word is kept for forwarding.
	always_ff @(posedge clk) begin
		if (msg_acc) begin
			unit_s1     <= unit;
			m_s1        <= m_in;
			addr_s1     <= addr_in;
			data_s1[0]  <= data_byte_1;
			data_s1[1]  <= data_byte_2;
			data_s1[2]  <= data_byte_3;
			data_s1[3]  <= data_byte_4;
			fwd_s1      <= wr_en && (addr_s1 == addr_in);
			fwd_word_s1 <= new_word;
		end
	end

	assign old_word = fwd_s1 ? fwd_word_s1 : rd_data;
	assign wide_s1  = m_s1.bank <= bfpc_pkg::BANK_BREAK;

	for (genvar n = 0; n < bfpc_pkg::CNT_NUM; n++) begin : g_cnt
		localparam int WG = n / bfpc_pkg::WIDE_BITS;
		localparam int WB = n % bfpc_pkg::WIDE_BITS;
		localparam int NG = n / bfpc_pkg::NARROW_BITS;
		localparam int NB = n % bfpc_pkg::NARROW_BITS;
		localparam bit WIDE_USED = n < bfpc_pkg::WIDE_GROUPS * bfpc_pkg::WIDE_BITS;

		logic                        flag;
		logic                        used;
		logic                        hit;
		logic [bfpc_pkg::CNT_W-1:0]  cur;
		logic [bfpc_pkg::CNT_W-1:0]  nxt;
		logic [bfpc_pkg::CNT_W:0]    inc;

		// The wide layout leaves the top counter untouched.
		always_comb begin
			cur  = old_word[n*bfpc_pkg::CNT_W +: bfpc_pkg::CNT_W];
			flag = wide_s1 ? data_s1[WG][WB] : data_s1[NG][NB];
			used = wide_s1 ? WIDE_USED : 1'b1;
			inc  = {1'b0, cur} + {{bfpc_pkg::CNT_W{1'b0}}, 1'b1};
			hit  = 1'b0;
			nxt  = cur;
			if (used) begin
				if (flag) begin
					hit = inc == TH_V;
					nxt = (inc > TH_V) ? SAT_V[bfpc_pkg::CNT_W-1:0] : inc[bfpc_pkg::CNT_W-1:0];
				end else begin
					nxt = '0;
				end
			end
		end

		assign new_word[n*bfpc_pkg::CNT_W +: bfpc_pkg::CNT_W] = nxt;
		assign hit_vec[n] = hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (v_s1 && s1_adv) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && s1_adv) begin
			unit_out_q <= unit_s1;
			matched_q  <= m_s1.matched;
			bank_q     <= m_s1.bank;
			fault_q    <= m_s1.matched && (|hit_vec);
		end
	end

	assign res_valid = res_valid_q;
	assign unit_out  = unit_out_q;
	assign matched   = matched_q;
	assign bank      = bank_q;
	assign fault     = fault_q;

	a_no_msg_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_ready |-> !clr_busy)
		else $error("message transfer during memory clearing");

	a_unmatched_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !matched |-> (bank == '0) && !fault)
		else $error("unmatched result carries a bank or a fault");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (addr_s1 <= AW'(DEPTH - 1)))
		else $error("counter write beyond memory depth");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !s1_adv |=> v_s1 && $stable(addr_s1))
		else $error("stalled message lost its entry");

endmodule

`default_nettype wire

FILE: tb/bit_fault_persistence_counter_tb.sv
// Self-checking testbench of the bit fault persistence counter with a built-in predictor.
`timescale 1ns / 100ps

module bit_fault_persistence_counter_tb;

	localparam int THRESH      = bfpc_pkg::FAULT_THRESHOLD_DEF;
	localparam int PHASES      = 5;
	localparam int PHASE_ITEMS = 186;

	typedef enum logic [1:0] {
		ACT_MSG,
		ACT_CODES,
		ACT_LAST
	} act_t;

	typedef struct packed {
		logic [bfpc_pkg::UNIT_W-1:0]                          unit;
		logic [bfpc_pkg::KIND_W-1:0]                          kind;
		logic [bfpc_pkg::BYTE_NUM-1:0][bfpc_pkg::BYTE_W-1:0]  data;
	} msg_t;

	typedef struct packed {
		logic [bfpc_pkg::UNIT_W-1:0] unit;
		logic                        matched;
		bfpc_pkg::bank_t             bank;
		logic                        fault;
	} verdict_t;

	typedef struct packed {
		act_t                                                 act;
		logic [bfpc_pkg::UNIT_W-1:0]                          unit;
		logic [bfpc_pkg::KIND_W-1:0]                          kind;
		logic [bfpc_pkg::BYTE_NUM-1:0][bfpc_pkg::BYTE_W-1:0]  data;
		logic [bfpc_pkg::PDATA_W-1:0]                         value;
		logic                                                 typed;
		logic                                                 matched;
		bfpc_pkg::bank_t                                      bank;
		logic                                                 fault;
	} step_t;

	// Data bytes are written byte 4 first, so the low byte is data_byte_1.
	localparam step_t DIRECTED [27] = '{
		'{ACT_MSG,   3'd0, 8'h00, 32'hffffffff, 64'd0, 1'b1, 1'b1, 4'd0, 1'b0},
		'{ACT_MSG,   3'd0, 8'h00, 32'hffffffff, 64'd0, 1'b1, 1'b1, 4'd0, 1'b0},
		'{ACT_MSG,   3'd0, 8'h00, 32'hffffffff, 64'd0, 1'b1, 1'b1, 4'd0, 1'b1},
		'{ACT_MSG,   3'd0, 8'h00, 32'hffffffff, 64'd0, 1'b1, 1'b1, 4'd0, 1'b0},
		'{ACT_MSG,   3'd7, 8'h5a, 32'hffffffff, 64'd0, 1'b1, 1'b0, 4'd0, 1'b0},
		'{ACT_MSG,   3'd0, 8'h00, 32'h00000000, 64'd0, 1'b1, 1'b1, 4'd0, 1'b0},
		'{ACT_CODES, 3'd0, 8'h00, 32'h0, 64'hff33_3340_3020_1000, 1'b0, 1'b0, 4'd0, 1'b0},
		'{ACT_LAST,  3'd0, 8'h00, 32'h0, 64'h77, 1'b0, 1'b0, 4'd0, 1'b0},
		'{ACT_MSG,   3'd3, 8'h77, 32'h0f0f0f0f, 64'd0, 1'b0, 1'b0, 4'd0, 1'b0},
		'{ACT_MSG,   3'd3, 8'h77, 32'h0f0f0f0f, 64'd0, 1'b0, 1'b0, 4'd0, 1'b0},
		'{ACT_MSG,   3'd3, 8'h77, 32'h0f0f0f0f, 64'd0, 1'b0, 1'b0, 4'd0, 1'b0},
		'{ACT_MSG,   3'd2, 8'h33, 32'h0a050a05, 64'd0, 1'b0, 1'b0, 4'd0, 1'b0},
		'{ACT_MSG,   3'd4, 8'hff, 32'hf0f0f0f0, 64'd0, 1'b1, 1'b1, 4'd7, 1'b0},
		'{ACT_MSG,   3'd1, 8'h10, 32'hff1f1f1f, 64'd0, 1'b0, 1'b0, 4'd0, 1'b0},
		'{ACT_MSG,   3'd1, 8'h10, 32'he0e0e0e0, 64'd0, 1'b1, 1'b1, 4'd1, 1'b0},
		'{ACT_MSG,   3'd5, 8'h20, 32'h55aa55aa, 64'd0, 1'b0, 1'b0, 4'd0, 1'b0},
		'{ACT_MSG,   3'd6, 8'h30, 32'hffffffff, 64'd0, 1'b0, 1'b0, 4'd0, 1'b0},
		'{ACT_MSG,   3'd6, 8'h40, 32'h12345678, 64'd0, 1'b0, 1'b0, 4'd0, 1'b0},
		'{ACT_MSG,   3'd5, 8'h00, 32'h1f1f1f1f, 64'd0, 1'b0, 1'b0, 4'd0, 1'b0},
		'{ACT_MSG,   3'd2, 8'h99, 32'hffffffff, 64'd0, 1'b1, 1'b0, 4'd0, 1'b0},
		'{ACT_CODES, 3'd0, 8'h00, 32'h0, 64'habab_abab_abab_abab, 1'b0, 1'b0, 4'd0, 1'b0},
		'{ACT_LAST,  3'd0, 8'h00, 32'h0, 64'hab, 1'b0, 1'b0, 4'd0, 1'b0},
		'{ACT_MSG,   3'd0, 8'hab, 32'hffffffff, 64'd0, 1'b0, 1'b0, 4'd0, 1'b0},
		'{ACT_CODES, 3'd0, 8'h00, 32'h0, 64'h0, 1'b0, 1'b0, 4'd0, 1'b0},
		'{ACT_LAST,  3'd0, 8'h00, 32'h0, 64'hff, 1'b0, 1'b0, 4'd0, 1'b0},
		'{ACT_MSG,   3'd7, 8'hff, 32'hffffffff, 64'd0, 1'b1, 1'b1, 4'd8, 1'b0},
		'{ACT_MSG,   3'd7, 8'h00, 32'h80808080, 64'd0, 1'b1, 1'b1, 4'd0, 1'b0}
	};

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            psel = 1'b0;
	logic                            penable = 1'b0;
	logic                            pwrite = 1'b0;
	logic [bfpc_pkg::PADDR_W-1:0]    paddr = '0;
	logic [bfpc_pkg::PDATA_W-1:0]    pwdata = '0;
	logic [bfpc_pkg::PDATA_W-1:0]    prdata;
	logic                            pready;
	logic                            msg_valid = 1'b0;
	logic                            msg_ready;
	logic [bfpc_pkg::UNIT_W-1:0]     unit = '0;
	logic [bfpc_pkg::KIND_W-1:0]     kind_byte = '0;
	logic [bfpc_pkg::BYTE_W-1:0]     data_byte_1 = '0;
	logic [bfpc_pkg::BYTE_W-1:0]     data_byte_2 = '0;
	logic [bfpc_pkg::BYTE_W-1:0]     data_byte_3 = '0;
	logic [bfpc_pkg::BYTE_W-1:0]     data_byte_4 = '0;
	logic                            res_valid;
	logic                            res_ready = 1'b0;
	logic [bfpc_pkg::UNIT_W-1:0]     unit_out;
	logic                            matched;
	logic [bfpc_pkg::BANK_W-1:0]     bank;
	logic                            fault;

	// Predictor state: the configured codes and one counter word per unit and bank.
	logic [bfpc_pkg::PDATA_W-1:0]    codes_reg = '0;
	logic [bfpc_pkg::KIND_W-1:0]     last_reg = '0;
	logic [bfpc_pkg::WORD_W-1:0]
		persist_words [bfpc_pkg::UNIT_COUNT_DEF][bfpc_pkg::BANK_COUNT];

	verdict_t              verdict_q [$];
	int                    n_errors = 0;
	int                    n_sent = 0;
	int                    n_results = 0;
	int                    n_faults = 0;
	int                    n_unmatched = 0;
	int                    n_cfg_writes = 0;
	bit                    calm = 1'b0;
	int                    hold_requests = 0;
	int                    holds_served = 0;
	int                    hold_left = 0;

	bit_fault_persistence_counter u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.msg_valid   (msg_valid),
		.msg_ready   (msg_ready),
		.unit        (unit),
		.kind_byte   (kind_byte),
		.data_byte_1 (data_byte_1),
		.data_byte_2 (data_byte_2),
		.data_byte_3 (data_byte_3),
		.data_byte_4 (data_byte_4),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.unit_out    (unit_out),
		.matched     (matched),
		.bank        (bank),
		.fault       (fault)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [63:0] exp_val,
		input logic [63:0] got_val);
		$display("%0t ns: %s differs, expected %0h, got %0h", $time, what, exp_val, got_val);
		n_errors++;
	endtask

	// Selects the bank of a message and advances its persistence counters.
	function automatic verdict_t apply_message(input msg_t m);
		verdict_t                    v;
		int                          sel;
		int                          groups;
		int                          width;
		int                          pos;
		int                          cnt;
		logic [bfpc_pkg::WORD_W-1:0] word;
		v.unit = m.unit;
		v.matched = 1'b0;
		v.bank = '0;
		v.fault = 1'b0;
		sel = -1;
		for (int b = 0; b < bfpc_pkg::CODE_NUM; b++)
			if (sel < 0 && codes_reg[bfpc_pkg::KIND_W*b +: bfpc_pkg::KIND_W] == m.kind)
				sel = b;
		if (sel < 0 && last_reg == m.kind)
			sel = bfpc_pkg::BANK_COUNT - 1;
		if (sel < 0 || int'(m.unit) >= bfpc_pkg::UNIT_COUNT_DEF)
			return v;
		if (bfpc_pkg::bank_t'(sel) <= bfpc_pkg::BANK_BREAK) begin
			groups = bfpc_pkg::WIDE_GROUPS;
			width = bfpc_pkg::WIDE_BITS;
		end else begin
			groups = bfpc_pkg::BYTE_NUM;
			width = bfpc_pkg::NARROW_BITS;
		end
		word = persist_words[m.unit][sel];
		for (int g = 0; g < groups; g++) begin
			for (int k = 0; k < width; k++) begin
				pos = (g * width + k) * bfpc_pkg::CNT_W;
				cnt = int'(word[pos +: bfpc_pkg::CNT_W]);
				if (m.data[g][k]) begin
					cnt++;
					if (cnt == THRESH)
						v.fault = 1'b1;
					if (cnt > THRESH)
						cnt = THRESH + 1;
				end else begin
					cnt = 0;
				end
				word[pos +: bfpc_pkg::CNT_W] = bfpc_pkg::CNT_W'(cnt);
			end
		end
		persist_words[m.unit][sel] = word;
		v.matched = 1'b1;
		v.bank = bfpc_pkg::bank_t'(sel);
		return v;
	endfunction

	// Called at a rising edge; returns at the edge where the transfer happens.
	task automatic send_message(input msg_t m, input bit typed, input verdict_t typed_v);
		verdict_t v;
		unit <= m.unit;
		kind_byte <= m.kind;
		data_byte_1 <= m.data[0];
		data_byte_2 <= m.data[1];
		data_byte_3 <= m.data[2];
		data_byte_4 <= m.data[3];
		msg_valid <= 1'b1;
		do @(posedge clk); while (msg_ready !== 1'b1);
		v = apply_message(m);
		verdict_q.push_back(typed ? typed_v : v);
		n_sent++;
	endtask

	// Each idle cycle is drawn on its own with a chance of 28 in 100 while the run is not calm.
	task automatic idle_gap();
		while (!calm && $urandom_range(0, 99) < 28) begin
			msg_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Registers are only written with no message in flight.
	task automatic wait_drained();
		msg_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write followed by a read back of the same register.
	task automatic write_reg(input bfpc_pkg::reg_idx_t idx,
		input logic [bfpc_pkg::PDATA_W-1:0] val);
		logic [bfpc_pkg::PDATA_W-1:0] readback;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= bfpc_pkg::PADDR_W'(idx) << bfpc_pkg::REG_SEL_BIT;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (idx == bfpc_pkg::REG_CODES) begin
			codes_reg = val;
			readback = val;
		end else begin
			last_reg = val[bfpc_pkg::KIND_W-1:0];
			readback = bfpc_pkg::PDATA_W'(val[bfpc_pkg::KIND_W-1:0]);
		end
		n_cfg_writes++;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== readback)
			report_mismatch("prdata", readback, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Result side: random stalls, plus long hold-offs on request.
	always @(posedge clk) begin
		if (holds_served != hold_requests) begin
			holds_served++;
			hold_left = 90;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= calm || ($urandom_range(0, 99) >= 28);
		end
	end

	always @(posedge clk) begin
		verdict_t v;
		if (arst_n && res_valid === 1'b1 && res_ready) begin
			n_results++;
			if (verdict_q.size() == 0) begin
				report_mismatch("outstanding message count", 64'd1, 64'd0);
			end else begin
				v = verdict_q.pop_front();
				if (unit_out !== v.unit)
					report_mismatch("unit_out", 64'(v.unit), 64'(unit_out));
				if (matched !== v.matched)
					report_mismatch("matched", 64'(v.matched), 64'(matched));
				if (bank !== v.bank)
					report_mismatch("bank", 64'(v.bank), 64'(bank));
				if (fault !== v.fault)
					report_mismatch("fault", 64'(v.fault), 64'(fault));
				if (v.fault)
					n_faults++;
				if (!v.matched)
					n_unmatched++;
			end
		end
	end

	initial begin
		msg_t                        m;
		verdict_t                    tv;
		int                          idx;
		logic [bfpc_pkg::KIND_W-1:0] code_byte;
		foreach (persist_words[u, b])
			persist_words[u][b] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].act == ACT_MSG) begin
				m.unit = DIRECTED[i].unit;
				m.kind = DIRECTED[i].kind;
				m.data = DIRECTED[i].data;
				tv.unit = DIRECTED[i].unit;
				tv.matched = DIRECTED[i].matched;
				tv.bank = DIRECTED[i].bank;
				tv.fault = DIRECTED[i].fault;
				send_message(m, DIRECTED[i].typed, tv);
				idle_gap();
			end else begin
				wait_drained();
				write_reg(DIRECTED[i].act == ACT_CODES ? bfpc_pkg::REG_CODES
					: bfpc_pkg::REG_LAST, DIRECTED[i].value);
			end
		end

		idx = 0;
		for (int p = 0; p < PHASES; p++) begin
			// The sender waits here until every outstanding result has come back.
			wait_drained();
			if (p == 0) begin
				write_reg(bfpc_pkg::REG_CODES, '1);
				write_reg(bfpc_pkg::REG_LAST, '0);
			end else if (p == PHASES - 1) begin
				write_reg(bfpc_pkg::REG_CODES, '0);
				write_reg(bfpc_pkg::REG_LAST, bfpc_pkg::PDATA_W'(8'hff));
			end else begin
				code_byte = bfpc_pkg::KIND_W'($urandom_range(0, 255));
				for (int b = 0; b < bfpc_pkg::CODE_NUM; b++) begin
					// Repeat the previous code now and then so that duplicates occur.
					if ($urandom_range(0, 3) != 0)
						code_byte = bfpc_pkg::KIND_W'($urandom_range(0, 255));
					codes_reg[bfpc_pkg::KIND_W*b +: bfpc_pkg::KIND_W] = code_byte;
				end
				write_reg(bfpc_pkg::REG_CODES, codes_reg);
				write_reg(bfpc_pkg::REG_LAST, bfpc_pkg::PDATA_W'($urandom_range(0, 255)));
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				calm = (idx >= 250 && idx < 400);
				if (idx == 260)
					hold_requests++;
				// Few hot units so that counters on the same word build up.
				m.unit = ($urandom_range(0, 9) < 7)
					? bfpc_pkg::UNIT_W'($urandom_range(0, 1))
					: bfpc_pkg::UNIT_W'($urandom_range(0, bfpc_pkg::UNIT_COUNT_DEF - 1));
				if ($urandom_range(0, 99) < 85) begin
					code_byte = bfpc_pkg::KIND_W'($urandom_range(0, bfpc_pkg::BANK_COUNT - 1));
					m.kind = (code_byte == bfpc_pkg::KIND_W'(bfpc_pkg::BANK_COUNT - 1))
						? last_reg
						: codes_reg[bfpc_pkg::KIND_W*code_byte +: bfpc_pkg::KIND_W];
				end else begin
					m.kind = bfpc_pkg::KIND_W'($urandom_range(0, 255));
				end
				for (int g = 0; g < bfpc_pkg::BYTE_NUM; g++)
					m.data[g] = ($urandom_range(0, 9) < 7)
						? bfpc_pkg::BYTE_W'($urandom | $urandom)
						: bfpc_pkg::BYTE_W'($urandom);
				send_message(m, 1'b0, tv);
				idle_gap();
				idx++;
			end
		end

		msg_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("Run covered %0d messages, %0d results, %0d register writes.",
			n_sent, n_results, n_cfg_writes);
		$display("Faults raised: %0d, unmatched messages: %0d.", n_faults, n_unmatched);
		if (n_errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Timeout with %0d results outstanding", verdict_q.size());
		$display("Mismatches found");
		$finish;
	end

endmodule
